FILE: design/grid_astar_path_search_assert.svh
// assertion macros shared by the grid path search checker
// expects clk and rst_n in the scope where the macros are used
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GAPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gaps_pkg.sv
// shared types and codes for the grid path search block
// no dependencies
package gaps_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_MAP_WRITE = 2'd0,
        REQ_SEARCH    = 2'd1,
        REQ_STEP_READ = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    // node status codes
    localparam logic [1:0] NODE_UNVISITED = 2'd0;
    localparam logic [1:0] NODE_OPEN      = 2'd1;
    localparam logic [1:0] NODE_CLOSED    = 2'd2;

    // step directions
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_START_X     = 3'd2;
    localparam logic [2:0] REG_START_Y     = 3'd3;
    localparam logic [2:0] REG_GOAL_X      = 3'd4;
    localparam logic [2:0] REG_GOAL_Y      = 3'd5;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_STEP_WAIT,
        S_CLEAR,
        S_RD_START,
        S_RD_GOAL,
        S_CHECK,
        S_SCAN,
        S_POP,
        S_POP_WAIT,
        S_NB_ISSUE,
        S_NB_CHECK,
        S_UPDATE,
        S_CLOSE,
        S_TRACE_RD,
        S_TRACE_WR,
        S_RESULT
    } state_t;

endpackage

FILE: design/grid_astar_path_search.sv
// grid path search: A* over a 4-connected grid with a Manhattan heuristic
// depends on gaps_pkg and gaps_ram
//
// Usage: a map of passable cells is loaded by req_type 0 transfers (no
// result). A req_type 1 transfer runs a search from the start to the goal set
// in the APB registers and returns one result with found and path_length.
// A req_type 2 transfer reads one step of the last found path by step_index
// and returns one result with step_dir and index_ok. req_type 3 is dropped.
// Step read: a registered path memory read, then S_STEP_WAIT and S_RESULT
// to the output register. Search: a clearing pass over all node store
// entries, then per expanded cell a linear scan of the open list (through
// the single open list memory port), a map and node read per neighbour plus
// a rescan when a neighbour cost drops, and a node read and a path write per
// path step for the trace back. The open list scan sets the search time.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; while the receiver stalls, map writes are still
// taken and the next result waits in the sequencer.
// Reset sets the grid size to 64 by 64 and start and goal to 0, clears the
// result (not found) and out_valid; map contents are undefined until written.
module grid_astar_path_search #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic        passable,
    input  logic [11:0] step_index,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [11:0] path_length,
    output logic [1:0]  step_dir,
    output logic        index_ok,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import gaps_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = $clog2(CELLS);
    localparam int GW    = CW + 1;
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int FW    = $clog2(CELLS + MAX_WIDTH + MAX_HEIGHT);
    localparam int EW    = FW + YB + XB;
    localparam int NW    = 2 + GW + 2;
    localparam int LW    = (GW > 12) ? GW : 12;

    // cell index from coordinates
    function automatic logic [CW-1:0] cell_addr(input logic [YB-1:0] y,
                                                 input logic [XB-1:0] x);
        return CW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // f = g + Manhattan distance to the goal
    function automatic logic [FW-1:0] f_value(input logic [GW-1:0] g,
                                              input logic [XB-1:0] x,
                                              input logic [YB-1:0] y,
                                              input logic [5:0]    gx,
                                              input logic [5:0]    gy);
        logic [8:0] ax;
        logic [8:0] ay;
        logic [8:0] bx;
        logic [8:0] by;
        ax = 9'(x);
        ay = 9'(y);
        bx = 9'(gx);
        by = 9'(gy);
        return FW'(g) + FW'((ax > bx) ? ax - bx : bx - ax)
                      + FW'((ay > by) ? ay - by : by - ay);
    endfunction

    // configuration registers
    logic [6:0] grid_width_reg;
    logic [6:0] grid_height_reg;
    logic [5:0] start_x_reg;
    logic [5:0] start_y_reg;
    logic [5:0] goal_x_reg;
    logic [5:0] goal_y_reg;

    // sequencer registers
    state_t          state_reg, state_next;
    logic [XW-1:0]   w_reg, w_next;
    logic [YW-1:0]   h_reg, h_next;
    logic [CW:0]     count_reg, count_next;
    logic [CW:0]     scan_i_reg, scan_i_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   pend_idx_reg, pend_idx_next;
    logic [EW-1:0]   best_reg, best_next;
    logic [CW-1:0]   best_idx_reg, best_idx_next;
    logic            best_ok_reg, best_ok_next;
    logic [CW:0]     clr_reg, clr_next;
    logic            start_ok_reg, start_ok_next;
    logic [XB-1:0]   cur_x_reg, cur_x_next;
    logic [YB-1:0]   cur_y_reg, cur_y_next;
    logic [GW-1:0]   cur_g_reg, cur_g_next;
    logic [1:0]      cur_came_reg, cur_came_next;
    logic [1:0]      dir_reg, dir_next;
    logic [XB-1:0]   nx_reg, nx_next;
    logic [YB-1:0]   ny_reg, ny_next;
    logic [GW-1:0]   trace_i_reg, trace_i_next;
    logic [XB-1:0]   tx_reg, tx_next;
    logic [YB-1:0]   ty_reg, ty_next;
    logic            res_found_reg, res_found_next;
    logic [GW-1:0]   res_len_reg, res_len_next;
    logic [1:0]      res_dir_reg, res_dir_next;
    logic            res_ok_reg, res_ok_next;
    logic            out_valid_reg, out_valid_next;
    logic            found_reg, found_next;
    logic [11:0]     path_length_reg, path_length_next;
    logic [1:0]      step_dir_reg, step_dir_next;
    logic            index_ok_reg, index_ok_next;

    // memory ports
    logic            map_we;
    logic [CW-1:0]   map_waddr, map_raddr;
    logic            map_wdata, map_q;
    logic            node_we;
    logic [CW-1:0]   node_waddr, node_raddr;
    logic [NW-1:0]   node_wdata, node_q;
    logic            open_we;
    logic [CW-1:0]   open_waddr, open_raddr;
    logic [EW-1:0]   open_wdata, open_q;
    logic            path_we;
    logic [CW-1:0]   path_waddr, path_raddr;
    logic [1:0]      path_wdata, path_q;

    // decoded node word and helpers
    logic [1:0]      nq_status;
    logic [GW-1:0]   nq_cost;
    logic [1:0]      nq_came;
    logic [GW-1:0]   ng;
    logic            in_xfer;
    logic            cfg_wr;
    logic [2:0]      reg_idx;
    logic            out_free;

    assign nq_status = node_q[NW-1 -: 2];
    assign nq_cost   = node_q[GW+1:2];
    assign nq_came   = node_q[1:0];
    assign ng        = cur_g_reg + GW'(1);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign reg_idx   = paddr[4:2];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign path_length = path_length_reg;
    assign step_dir    = step_dir_reg;
    assign index_ok    = index_ok_reg;

    // register read mux
    always_comb
    begin
        case (reg_idx)
            REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            REG_START_X:     prdata = 32'(start_x_reg);
            REG_START_Y:     prdata = 32'(start_y_reg);
            REG_GOAL_X:      prdata = 32'(goal_x_reg);
            REG_GOAL_Y:      prdata = 32'(goal_y_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            start_x_reg     <= 6'd0;
            start_y_reg     <= 6'd0;
            goal_x_reg      <= 6'd0;
            goal_y_reg      <= 6'd0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[6:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[6:0];
                REG_START_X:     start_x_reg     <= pwdata[5:0];
                REG_START_Y:     start_y_reg     <= pwdata[5:0];
                REG_GOAL_X:      goal_x_reg      <= pwdata[5:0];
                REG_GOAL_Y:      goal_y_reg      <= pwdata[5:0];
                default:         ;
            endcase
        end
    end

    // memories
    gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_q)
    );

    gaps_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_node (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_q)
    );

    gaps_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_open (
        .clk(clk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
        .raddr(open_raddr), .rdata(open_q)
    );

    gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_path (
        .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
        .raddr(path_raddr), .rdata(path_q)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_found_reg <= 1'b0;
            res_len_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            best_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_found_reg <= res_found_next;
            res_len_reg   <= res_len_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            best_ok_reg   <= best_ok_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_reg           <= w_next;
        h_reg           <= h_next;
        scan_i_reg      <= scan_i_next;
        pend_idx_reg    <= pend_idx_next;
        best_reg        <= best_next;
        best_idx_reg    <= best_idx_next;
        clr_reg         <= clr_next;
        start_ok_reg    <= start_ok_next;
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        cur_g_reg       <= cur_g_next;
        cur_came_reg    <= cur_came_next;
        dir_reg         <= dir_next;
        nx_reg          <= nx_next;
        ny_reg          <= ny_next;
        trace_i_reg     <= trace_i_next;
        tx_reg          <= tx_next;
        ty_reg          <= ty_next;
        res_dir_reg     <= res_dir_next;
        res_ok_reg      <= res_ok_next;
        found_reg       <= found_next;
        path_length_reg <= path_length_next;
        step_dir_reg    <= step_dir_next;
        index_ok_reg    <= index_ok_next;
    end

    // sequencer: next state, memory ports and outputs
    always_comb
    begin
        logic          nb_ok;
        logic [XB-1:0] nbx;
        logic [YB-1:0] nby;
        logic          last_dir;

        state_next       = state_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        count_next       = count_reg;
        scan_i_next      = scan_i_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        best_ok_next     = best_ok_reg;
        clr_next         = clr_reg;
        start_ok_next    = start_ok_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_g_next       = cur_g_reg;
        cur_came_next    = cur_came_reg;
        dir_next         = dir_reg;
        nx_next          = nx_reg;
        ny_next          = ny_reg;
        trace_i_next     = trace_i_reg;
        tx_next          = tx_reg;
        ty_next          = ty_reg;
        res_found_next   = res_found_reg;
        res_len_next     = res_len_reg;
        res_dir_next     = res_dir_reg;
        res_ok_next      = res_ok_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        path_length_next = path_length_reg;
        step_dir_next    = step_dir_reg;
        index_ok_next    = index_ok_reg;

        map_we     = 1'b0;
        map_waddr  = cell_addr(YB'(cell_y), XB'(cell_x));
        map_wdata  = passable;
        map_raddr  = cell_addr(YB'(start_y_reg), XB'(start_x_reg));
        node_we    = 1'b0;
        node_waddr = cell_addr(cur_y_reg, cur_x_reg);
        node_wdata = {NODE_CLOSED, cur_g_reg, cur_came_reg};
        node_raddr = cell_addr(cur_y_reg, cur_x_reg);
        open_we    = 1'b0;
        open_waddr = best_idx_reg;
        open_wdata = open_q;
        open_raddr = CW'(scan_i_reg);
        path_we    = 1'b0;
        path_waddr = CW'(trace_i_reg - GW'(1));
        path_wdata = nq_came;
        path_raddr = CW'(step_index);

        nb_ok    = 1'b0;
        nbx      = cur_x_reg;
        nby      = cur_y_reg;
        last_dir = (dir_reg == DIR_DOWN);

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (req_type)
                        REQ_MAP_WRITE:
                        begin
                            map_we = (int'(cell_x) < MAX_WIDTH)
                                  && (int'(cell_y) < MAX_HEIGHT);
                        end
                        REQ_SEARCH:
                        begin
                            // clamp the grid size and start the clearing pass
                            if (grid_width_reg == 7'd0)
                                w_next = XW'(1);
                            else if (int'(grid_width_reg) > MAX_WIDTH)
                                w_next = XW'(MAX_WIDTH);
                            else
                                w_next = XW'(grid_width_reg);
                            if (grid_height_reg == 7'd0)
                                h_next = YW'(1);
                            else if (int'(grid_height_reg) > MAX_HEIGHT)
                                h_next = YW'(MAX_HEIGHT);
                            else
                                h_next = YW'(grid_height_reg);
                            res_found_next = 1'b0;
                            res_len_next   = '0;
                            res_dir_next   = DIR_LEFT;
                            res_ok_next    = 1'b0;
                            count_next     = '0;
                            clr_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        REQ_STEP_READ:
                        begin
                            res_ok_next = res_found_reg
                                       && (LW'(step_index) < LW'(res_len_reg));
                            state_next  = S_STEP_WAIT;
                        end
                        default: ;
                    endcase
                end
            end

            S_STEP_WAIT:
            begin
                res_dir_next = res_ok_reg ? path_q : DIR_LEFT;
                state_next   = S_RESULT;
            end

            S_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = CW'(clr_reg);
                node_wdata = '0;
                clr_next   = clr_reg + (CW+1)'(1);
                if (clr_reg == (CW+1)'(CELLS - 1))
                    state_next = S_RD_START;
            end

            S_RD_START:
            begin
                if ((XW'(start_x_reg) >= w_reg) || (9'(start_x_reg) >= 9'(w_reg))
                    || (9'(start_y_reg) >= 9'(h_reg)) || (9'(goal_x_reg) >= 9'(w_reg))
                    || (9'(goal_y_reg) >= 9'(h_reg)))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    map_raddr  = cell_addr(YB'(start_y_reg), XB'(start_x_reg));
                    state_next = S_RD_GOAL;
                end
            end

            S_RD_GOAL:
            begin
                start_ok_next = map_q;
                map_raddr     = cell_addr(YB'(goal_y_reg), XB'(goal_x_reg));
                state_next    = S_CHECK;
            end

            S_CHECK:
            begin
                if (start_ok_reg && map_q)
                begin
                    node_we      = 1'b1;
                    node_waddr   = cell_addr(YB'(start_y_reg), XB'(start_x_reg));
                    node_wdata   = {NODE_OPEN, GW'(0), DIR_LEFT};
                    open_we      = 1'b1;
                    open_waddr   = '0;
                    open_wdata   = {f_value(GW'(0), XB'(start_x_reg), YB'(start_y_reg),
                                            goal_x_reg, goal_y_reg),
                                    YB'(start_y_reg), XB'(start_x_reg)};
                    count_next   = (CW+1)'(1);
                    scan_i_next  = '0;
                    pend_next    = 1'b0;
                    best_ok_next = 1'b0;
                    state_next   = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_SCAN:
            begin
                // pipelined minimum search over the open list
                if (pend_reg && (!best_ok_reg || (open_q < best_reg)))
                begin
                    best_next     = open_q;
                    best_idx_next = pend_idx_reg;
                    best_ok_next  = 1'b1;
                end
                pend_next = 1'b0;
                if (scan_i_reg < count_reg)
                begin
                    open_raddr    = CW'(scan_i_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = CW'(scan_i_reg);
                    scan_i_next   = scan_i_reg + (CW+1)'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = best_ok_reg ? S_POP : S_RESULT;
                end
            end

            S_POP:
            begin
                cur_x_next = best_reg[XB-1:0];
                cur_y_next = best_reg[XB+YB-1:XB];
                count_next = count_reg - (CW+1)'(1);
                open_raddr = CW'(count_reg - (CW+1)'(1));
                node_raddr = cell_addr(best_reg[XB+YB-1:XB], best_reg[XB-1:0]);
                state_next = S_POP_WAIT;
            end

            S_POP_WAIT:
            begin
                // move the last entry into the freed slot
                open_we       = 1'b1;
                open_waddr    = best_idx_reg;
                open_wdata    = open_q;
                cur_g_next    = nq_cost;
                cur_came_next = nq_came;
                if ((9'(cur_x_reg) == 9'(goal_x_reg)) && (9'(cur_y_reg) == 9'(goal_y_reg)))
                begin
                    trace_i_next = nq_cost;
                    tx_next      = cur_x_reg;
                    ty_next      = cur_y_reg;
                    state_next   = S_TRACE_RD;
                end
                else
                begin
                    dir_next   = DIR_LEFT;
                    state_next = S_NB_ISSUE;
                end
            end

            S_NB_ISSUE:
            begin
                case (dir_reg)
                    DIR_LEFT:
                    begin
                        nb_ok = (cur_x_reg != '0);
                        nbx   = cur_x_reg - XB'(1);
                    end
                    DIR_RIGHT:
                    begin
                        nb_ok = ((XW'(cur_x_reg) + XW'(1)) < w_reg);
                        nbx   = cur_x_reg + XB'(1);
                    end
                    DIR_UP:
                    begin
                        nb_ok = (cur_y_reg != '0);
                        nby   = cur_y_reg - YB'(1);
                    end
                    DIR_DOWN:
                    begin
                        nb_ok = ((YW'(cur_y_reg) + YW'(1)) < h_reg);
                        nby   = cur_y_reg + YB'(1);
                    end
                    default: ;
                endcase
                nx_next    = nbx;
                ny_next    = nby;
                map_raddr  = cell_addr(nby, nbx);
                node_raddr = cell_addr(nby, nbx);
                if (nb_ok)
                    state_next = S_NB_CHECK;
                else if (last_dir)
                    state_next = S_CLOSE;
                else
                    dir_next = dir_reg + 2'd1;
            end

            S_NB_CHECK:
            begin
                node_waddr = cell_addr(ny_reg, nx_reg);
                node_wdata = {NODE_OPEN, ng, dir_reg};
                open_waddr = CW'(count_reg);
                open_wdata = {f_value(ng, nx_reg, ny_reg, goal_x_reg, goal_y_reg),
                              ny_reg, nx_reg};
                if (map_q && (nq_status == NODE_UNVISITED))
                begin
                    node_we = 1'b1;
                    if (count_reg < (CW+1)'(CELLS))
                    begin
                        open_we    = 1'b1;
                        count_next = count_reg + (CW+1)'(1);
                    end
                end
                else if (map_q && (nq_status == NODE_OPEN) && (ng < nq_cost))
                begin
                    node_we     = 1'b1;
                    scan_i_next = '0;
                    pend_next   = 1'b0;
                    state_next  = S_UPDATE;
                end
                if (state_next != S_UPDATE)
                begin
                    if (last_dir)
                        state_next = S_CLOSE;
                    else
                    begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = S_NB_ISSUE;
                    end
                end
            end

            S_UPDATE:
            begin
                // rewrite the open entry of the improved neighbour
                open_waddr = pend_idx_reg;
                open_wdata = {f_value(ng, nx_reg, ny_reg, goal_x_reg, goal_y_reg),
                              ny_reg, nx_reg};
                open_we    = pend_reg && (open_q[XB-1:0] == nx_reg)
                          && (open_q[XB+YB-1:XB] == ny_reg);
                pend_next  = 1'b0;
                if (scan_i_reg < count_reg)
                begin
                    open_raddr    = CW'(scan_i_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = CW'(scan_i_reg);
                    scan_i_next   = scan_i_reg + (CW+1)'(1);
                end
                else if (!pend_reg)
                begin
                    if (last_dir)
                        state_next = S_CLOSE;
                    else
                    begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = S_NB_ISSUE;
                    end
                end
            end

            S_CLOSE:
            begin
                node_we      = 1'b1;
                node_waddr   = cell_addr(cur_y_reg, cur_x_reg);
                node_wdata   = {NODE_CLOSED, cur_g_reg, cur_came_reg};
                scan_i_next  = '0;
                pend_next    = 1'b0;
                best_ok_next = 1'b0;
                state_next   = S_SCAN;
            end

            S_TRACE_RD:
            begin
                node_raddr = cell_addr(ty_reg, tx_reg);
                if (trace_i_reg == '0)
                begin
                    res_found_next = 1'b1;
                    res_len_next   = cur_g_reg;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_TRACE_WR;
                end
            end

            S_TRACE_WR:
            begin
                // store the step and walk back against it
                path_we      = 1'b1;
                path_waddr   = CW'(trace_i_reg - GW'(1));
                path_wdata   = nq_came;
                trace_i_next = trace_i_reg - GW'(1);
                case (nq_came)
                    DIR_LEFT:  tx_next = tx_reg + XB'(1);
                    DIR_RIGHT: tx_next = tx_reg - XB'(1);
                    DIR_UP:    ty_next = ty_reg + YB'(1);
                    default:   ty_next = ty_reg - YB'(1);
                endcase
                state_next = S_TRACE_RD;
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = res_found_reg;
                    path_length_next = (LW'(res_len_reg) > LW'(4095))
                                     ? 12'd4095 : 12'(res_len_reg);
                    step_dir_next    = res_dir_reg;
                    index_ok_next    = res_ok_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/gaps_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/gaps_checker.sv
// port-level checks for the grid path search block, bound to the top level
// depends on grid_astar_path_search_assert.svh
`include "grid_astar_path_search_assert.svh"

module gaps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [11:0] path_length,
    input logic [1:0]  step_dir,
    input logic        index_ok
);

    // a stalled result stays offered
    `GAPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // a valid step index needs a found path
    `GAPS_ASSERT_IMP(a_ok_found, out_valid && index_ok, found && (path_length != 12'd0), "index_ok without path")
    // no path means zero length
    `GAPS_ASSERT_IMP(a_len_zero, out_valid && !found, path_length == 12'd0, "length without path")
    // rejected step reads give direction zero
    `GAPS_ASSERT_IMP(a_dir_zero, out_valid && !index_ok, step_dir == 2'd0, "direction on rejected read")

endmodule

bind grid_astar_path_search gaps_checker u_gaps_checker (.*);
